>>> hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

>>> hdl/litc_pkg.sv
package litc_pkg;

  localparam int unsigned MaxRank = 6;
  localparam int unsigned DimW    = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QDepth  = 2;

  localparam logic [CfgIdxW-1:0] CfgRank = 3'd0;

  // One queued job: the index and the rank it was accepted with.
  typedef struct packed {
    logic [DataW-1:0] index;
    logic [DimW-1:0]  rank;
  } job_t;

endpackage

>>> hdl/litc_front.sv
module litc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [litc_pkg::DataW-1:0]  index_i,
  input  logic [litc_pkg::DimW-1:0]   rank_cfg_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output litc_pkg::job_t              job_o
);

  litc_pkg::job_t             mem_q [litc_pkg::QDepth];
  logic                       wr_q, wr_d, rd_q, rd_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic [litc_pkg::DimW-1:0]  rank_clamped;
  logic                       push, pop;

  always_comb begin
    rank_clamped = rank_cfg_i;
    if (rank_cfg_i == '0) begin
      rank_clamped = litc_pkg::DimW'(1);
    end else if (rank_cfg_i > litc_pkg::DimW'(litc_pkg::MaxRank)) begin
      rank_clamped = litc_pkg::DimW'(litc_pkg::MaxRank);
    end
  end

  assign in_ready_o  = (cnt_q != 2'(litc_pkg::QDepth));
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;
  assign wr_d        = push ? ~wr_q : wr_q;
  assign rd_d        = pop ? ~rd_q : rd_q;
  assign cnt_d       = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{index: index_i, rank: rank_clamped};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hdl/litc_divider.sv
module litc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [litc_pkg::DataW-1:0]  dividend_i,
  input  logic [litc_pkg::DataW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [litc_pkg::DataW-1:0]  quot_o,
  output logic [litc_pkg::DataW-1:0]  rem_o
);

  localparam int unsigned BitsPerCycle = 4;
  localparam int unsigned Steps        = litc_pkg::DataW / BitsPerCycle;
  localparam int unsigned StepW        = $clog2(Steps);

  logic                         busy_q;
  logic [StepW-1:0]             step_q;
  logic [litc_pkg::DataW-1:0]   quot_q, quot_d;
  logic [litc_pkg::DataW:0]     rem_q, rem_d;
  logic [litc_pkg::DataW-1:0]   div_q;

  // Restoring division, four quotient bits a cycle.
  always_comb begin
    logic [litc_pkg::DataW:0] r;
    logic [litc_pkg::DataW-1:0] q;
    r = rem_q;
    q = quot_q;
    for (int b = 0; b < BitsPerCycle; b++) begin
      r = {r[litc_pkg::DataW-1:0], q[litc_pkg::DataW-1]};
      q = {q[litc_pkg::DataW-2:0], 1'b0};
      if (r >= {1'b0, div_q}) begin
        r    = r - {1'b0, div_q};
        q[0] = 1'b1;
      end
    end
    rem_d  = r;
    quot_d = q;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q[litc_pkg::DataW-1:0];

endmodule

>>> hdl/litc_back.sv
module litc_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    job_valid_i,
  output logic                                    job_ready_o,
  input  litc_pkg::job_t                          job_i,
  input  logic [litc_pkg::MaxRank-1:0][litc_pkg::DataW-1:0] strides_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [litc_pkg::DimW-1:0]               dimension_o,
  output logic [litc_pkg::DataW-1:0]              coordinate_o,
  output logic                                    last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]                 state_q;
  logic [litc_pkg::DataW-1:0] rem_q;
  logic [litc_pkg::DataW-1:0] coord_q;
  logic [litc_pkg::DimW-1:0]  dim_q, rank_q;
  logic                       start;
  logic                       done;
  logic                       div_busy_q;
  logic [litc_pkg::DataW-1:0] quot, rem;
  logic [litc_pkg::DataW-1:0] stride;
  logic                       out_free;
  logic                       emit;

  assign stride      = strides_i[dim_q];
  assign out_free    = !out_valid_o || out_ready_i;
  assign emit        = (state_q == StOut) && out_free;
  assign job_ready_o = (state_q == StIdle);
  assign start       = (state_q == StDiv) && (stride != '0) && !done;

  litc_divider u_div (
    .clk_i, .rst_ni,
    .start_i    (start && !div_busy_q),
    .dividend_i (rem_q),
    .divisor_i  (stride),
    .done_o     (done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      div_busy_q   <= 1'b0;
      out_valid_o  <= 1'b0;
      dim_q        <= '0;
      rank_q       <= '0;
      rem_q        <= '0;
      coord_q      <= '0;
      dimension_o  <= '0;
      coordinate_o <= '0;
      last_o       <= 1'b0;
    end else begin
      // The result register holds its beat until the receiver takes it.
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            rem_q   <= job_i.index;
            rank_q  <= job_i.rank;
            dim_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (stride == '0) begin
            coord_q <= '1;
            state_q <= StOut;
          end else if (done) begin
            div_busy_q <= 1'b0;
            coord_q    <= quot;
            rem_q      <= rem;
            state_q    <= StOut;
          end else begin
            div_busy_q <= 1'b1;
          end
        end
        StOut: begin
          if (out_free) begin
            dimension_o  <= dim_q;
            coordinate_o <= coord_q;
            last_o       <= (dim_q + 1'b1 == rank_q);
            if (dim_q + 1'b1 == rank_q) begin
              state_q <= StIdle;
            end else begin
              dim_q   <= dim_q + 1'b1;
              state_q <= StDiv;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> hdl/linear_index_to_coordinates.sv
// Per dimension the back end starts the divider, runs eight radix-16 division
// steps, captures the quotient and emits the result beat; a zero stride skips
// the divider. The back end works on one index at a time, held by the single
// iterative divider; the two-entry job queue takes new indices meanwhile.
// Reset: asynchronous, active low; rank resets to 1 and all strides to 1.
`include "assert_macros.svh"

module linear_index_to_coordinates (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [litc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [litc_pkg::DataW-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [litc_pkg::DataW-1:0]         linear_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [litc_pkg::DimW-1:0]          dimension_o,
  output logic [litc_pkg::DataW-1:0]         coordinate_o,
  output logic                               last_o
);

  // Configuration registers. Index 0 is the rank, indices 1 to 6 the
  // strides; higher indices are dropped.
  logic [litc_pkg::DimW-1:0]                          rank_q;
  logic [litc_pkg::MaxRank-1:0][litc_pkg::DataW-1:0]  stride_q;
  logic                                               job_valid, job_ready;
  litc_pkg::job_t                                     job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= litc_pkg::DimW'(1);
      for (int k = 0; k < litc_pkg::MaxRank; k++) begin
        stride_q[k] <= litc_pkg::DataW'(1);
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == litc_pkg::CfgRank) begin
        rank_q <= cfg_data_i[litc_pkg::DimW-1:0];
      end else if (cfg_index_i <= litc_pkg::CfgIdxW'(litc_pkg::MaxRank)) begin
        stride_q[cfg_index_i - 1'b1] <= cfg_data_i;
      end
    end
  end

  // The front end clamps the rank and queues each beat.
  litc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .index_i     (linear_index_i),
    .rank_cfg_i  (rank_q),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // The back end walks the dimensions and emits one beat per coordinate.
  litc_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .strides_i   (stride_q),
    .out_valid_o,
    .out_ready_i,
    .dimension_o,
    .coordinate_o,
    .last_o
  );

  `ASSERT_CLK(a_last_dim_ok, clk_i, rst_ni,
    out_valid_o && last_o |-> dimension_o < litc_pkg::DimW'(litc_pkg::MaxRank),
    "last beat carries an out-of-range dimension")
  `ASSERT_CLK(a_dim_range, clk_i, rst_ni,
    out_valid_o |-> dimension_o < litc_pkg::DimW'(litc_pkg::MaxRank),
    "dimension out of range")

endmodule
